### sv/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

### sv/bmct_pkg.sv
// types and constants of the bus master transaction engine
`timescale 1ns / 1ps
`default_nettype none
package bmct_pkg;

  localparam int MAX_REPLY_BYTES = 10;
  localparam int IDX_W = $clog2(MAX_REPLY_BYTES);

  localparam logic [7:0] HDR0          = 8'h4A;
  localparam logic [7:0] HDR1          = 8'h54;
  localparam logic [7:0] REQ_LEN       = 8'd6;
  localparam logic [7:0] CMD_SHORT_END = 8'h20;
  localparam logic [7:0] CMD_LONG_END  = 8'h50;
  localparam logic [7:0] DEV_ERR_CODE  = 8'hFF;
  localparam logic [3:0] LEN_SHORT     = 4'd6;
  localparam logic [3:0] LEN_LONG      = 4'd10;
  localparam logic [3:0] ATTEMPT_RESET = 4'd4;

  localparam int BEAT_W = 3;
  localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(REQ_LEN - 8'd1);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_FIELD_W = 50;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_BYTE  = 2'd1,
    REQ_TICK  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DEV_ERR  = 2'd1,
    ST_NO_REPLY = 2'd2,
    ST_REJECTED = 2'd3
  } status_t;

  typedef enum logic {
    OUT_TX   = 1'b0,
    OUT_DONE = 1'b1
  } out_kind_t;

  typedef enum logic {
    CMD_SEND = 1'b0,
    CMD_DONE = 1'b1
  } cmd_kind_t;

  typedef enum logic {
    PH_IDLE = 1'b0,
    PH_WAIT = 1'b1
  } ph_state_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_SEND = 1'b1
  } bk_state_t;

  // one queued job for the back end
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  addr;
    logic [7:0]  cmd;
    status_t     status;
    logic [7:0]  code;
    logic [31:0] data;
  } bmct_job_t;

endpackage
`default_nettype wire

### sv/bus_master_command_transaction.sv
// top level of the bus master transaction engine
`timescale 1ns / 1ps
`default_nettype none
// bus master transaction engine. a start beat (tuser 0) with node address and
// command is classified: commands below 0x20 expect a 6-byte reply, 0x21 to
// 0x4f a 10-byte reply, anything else finishes at once with status rejected.
// an accepted command sends the 6-byte request 'J','T',addr,6,cmd,xor as six
// transmit beats, tlast on the sixth. receive beats (tuser 1) are hunted for
// the 'J','T' header; a complete reply with matching address, length and xor
// gives one finished beat (ok, or device error when byte four is 0xff, with
// the big-endian sensor word of a 10-byte reply). a window-end beat (tuser 2)
// resends the request until attempt_limit sends are used, then finishes with
// status no valid reply. the front end takes one input beat per cycle while
// its four-entry job queue has room; the back end drives one output beat per
// cycle while m_axis_tready does not hold it, a request frame as six beats and
// a finished result as one. a taken input beat passes the job queue and the
// output register before it shows. the user must write attempt_limit on the
// cfg channel only while no transaction is in flight; this is not enforced.
module bus_master_command_transaction
  import bmct_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // attempt_limit register
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [3:0]             cfg_data,      // attempt_limit
  // request beats
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // dest_addr, cmd_code, rx_byte
  input  wire logic [1:0]             s_axis_tuser,  // req_type
  // transmit and result beats
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // tx_byte, status, reply_code,
                                                     // sensor_data, zero pad
  output logic                        m_axis_tuser,  // out_kind
  output logic                        m_axis_tlast   // last
);

  // job handoff between front and back end
  logic      push;
  bmct_job_t push_data;
  logic      q_full;
  logic      pop;
  bmct_job_t q_head;
  logic      q_empty;

  bmct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .req_type  (s_axis_tuser),
    .dest_addr (s_axis_tdata[7:0]),
    .cmd_code  (s_axis_tdata[15:8]),
    .rx_byte   (s_axis_tdata[23:16]),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // decouples request handling from the slower frame serialiser
  bmct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  bmct_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

### sv/bmct_queue.sv
// small job queue between front and back end
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bmct_queue
  import bmct_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire bmct_job_t push_data,
  output logic           full,
  input  wire logic      pop,
  output bmct_job_t      head,
  output logic           empty
);

  bmct_job_t         slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_push_when_full, clk, rst, push && full)
  `ASSERT_NEVER(a_pop_when_empty, clk, rst, pop && empty)

endmodule
`default_nettype wire

### sv/bmct_front.sv
// front end: request decode, reply frame hunt and check, retry count
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bmct_front
  import bmct_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [3:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] req_type,
  input  wire logic [7:0] dest_addr,
  input  wire logic [7:0] cmd_code,
  input  wire logic [7:0] rx_byte,
  output logic            push,
  output bmct_job_t       push_data,
  input  wire logic       q_full
);

  ph_state_t        phase;
  ph_state_t        phase_next;
  logic [3:0]       attempt_limit;
  logic [7:0]       target_addr;
  logic [7:0]       saved_cmd;
  logic [3:0]       reply_length;
  logic [3:0]       attempts_left;
  logic [IDX_W-1:0] byte_count;
  logic [7:0]       running_xor;
  logic [7:0]       frame_store [MAX_REPLY_BYTES];

  logic             acc;
  logic             cmd_short;
  logic             cmd_long;
  logic             start_ok;

  // hunt datapath
  logic [IDX_W-1:0] bc_hunt;
  logic [7:0]       xor_hunt;
  logic             store_we;
  logic [IDX_W-1:0] store_idx;
  logic             frame_good;

  // register next values
  logic             load_job;
  logic [IDX_W-1:0] byte_count_next;
  logic [7:0]       running_xor_next;
  logic [3:0]       attempts_left_next;
  logic             store_en;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign acc       = in_valid && in_ready;
  assign cmd_short = (cmd_code < CMD_SHORT_END);
  assign cmd_long  = (cmd_code > CMD_SHORT_END) && (cmd_code < CMD_LONG_END);
  assign start_ok  = cmd_short || cmd_long;

  // header hunt and frame collection for one received byte
  always_comb begin
    bc_hunt    = byte_count;
    xor_hunt   = running_xor;
    store_we   = 1'b0;
    store_idx  = byte_count;
    frame_good = 1'b0;
    if (byte_count == '0) begin
      if (rx_byte == HDR0) begin
        store_we = 1'b1;
        xor_hunt = rx_byte;
        bc_hunt  = IDX_W'(1);
      end
    end else if (byte_count == IDX_W'(1)) begin
      if (rx_byte == HDR1) begin
        store_we = 1'b1;
        xor_hunt = running_xor ^ rx_byte;
        bc_hunt  = IDX_W'(2);
      end else if (rx_byte == HDR0) begin
        store_we  = 1'b1;
        store_idx = '0;
        xor_hunt  = rx_byte;
      end else begin
        bc_hunt = '0;
      end
    end else if ((byte_count >= reply_length) ||
                 (byte_count >= IDX_W'(MAX_REPLY_BYTES))) begin
      bc_hunt = '0;
    end else begin
      store_we = 1'b1;
      if (({1'b0, byte_count} + 5'd1) < {1'b0, reply_length}) begin
        xor_hunt = running_xor ^ rx_byte;
        bc_hunt  = byte_count + 1'b1;
      end else begin
        bc_hunt    = '0;
        frame_good = (frame_store[2] == target_addr) &&
                     (frame_store[3] == {4'b0, reply_length}) &&
                     (rx_byte == running_xor);
      end
    end
  end

  // phase next state
  always_comb begin
    phase_next = phase;
    if (acc) begin
      case (req_t'(req_type))
        REQ_START: begin
          if (phase == PH_IDLE && start_ok) phase_next = PH_WAIT;
        end
        REQ_BYTE: begin
          if (phase == PH_WAIT && frame_good) phase_next = PH_IDLE;
        end
        REQ_TICK: begin
          if (phase == PH_WAIT && attempts_left == '0) phase_next = PH_IDLE;
        end
        default: phase_next = phase;
      endcase
    end
  end

  // jobs for the back end and datapath register updates
  always_comb begin
    push               = 1'b0;
    push_data          = '{kind: CMD_SEND, addr: target_addr, cmd: saved_cmd,
                           status: ST_OK, code: 8'h00, data: 32'h0};
    load_job           = 1'b0;
    byte_count_next    = byte_count;
    running_xor_next   = running_xor;
    attempts_left_next = attempts_left;
    store_en           = 1'b0;
    if (acc) begin
      case (req_t'(req_type))
        REQ_START: begin
          if (phase == PH_IDLE) begin
            push = 1'b1;
            if (start_ok) begin
              load_job           = 1'b1;
              push_data.addr     = dest_addr;
              push_data.cmd      = cmd_code;
              byte_count_next    = '0;
              running_xor_next   = 8'h00;
              attempts_left_next = (attempt_limit == '0) ? 4'd0 : attempt_limit - 4'd1;
            end else begin
              push_data.kind   = CMD_DONE;
              push_data.status = ST_REJECTED;
            end
          end
        end
        REQ_BYTE: begin
          if (phase == PH_WAIT) begin
            store_en         = store_we;
            byte_count_next  = bc_hunt;
            running_xor_next = xor_hunt;
            if (frame_good) begin
              push           = 1'b1;
              push_data.kind = CMD_DONE;
              if (frame_store[4] == DEV_ERR_CODE) begin
                push_data.status = ST_DEV_ERR;
                push_data.code   = DEV_ERR_CODE;
              end else begin
                push_data.code = frame_store[4];
                if (reply_length == LEN_LONG) begin
                  push_data.data = {frame_store[5], frame_store[6],
                                    frame_store[7], frame_store[8]};
                end
              end
            end
          end
        end
        REQ_TICK: begin
          if (phase == PH_WAIT) begin
            push            = 1'b1;
            byte_count_next = '0;
            if (attempts_left != '0) begin
              attempts_left_next = attempts_left - 4'd1;
              running_xor_next   = 8'h00;
            end else begin
              push_data.kind   = CMD_DONE;
              push_data.status = ST_NO_REPLY;
            end
          end
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      frame_store[store_idx] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      attempt_limit <= ATTEMPT_RESET;
      target_addr   <= '0;
      saved_cmd     <= '0;
      reply_length  <= '0;
      attempts_left <= '0;
      byte_count    <= '0;
      running_xor   <= '0;
    end else begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      running_xor   <= running_xor_next;
      attempts_left <= attempts_left_next;
      if (cfg_valid && cfg_ready) begin
        attempt_limit <= cfg_data;
      end
      if (load_job) begin
        target_addr  <= dest_addr;
        saved_cmd    <= cmd_code;
        reply_length <= cmd_short ? LEN_SHORT : LEN_LONG;
      end
    end
  end

  `ASSERT_ALWAYS(a_idle_not_hunting, clk, rst, phase == PH_IDLE |-> byte_count == '0)

endmodule
`default_nettype wire

### sv/bmct_back.sv
// back end: frame serialiser and result beat register
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bmct_back
  import bmct_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire bmct_job_t         q_head,
  output logic                   pop,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast
);

  bk_state_t         state;
  bk_state_t         state_next;
  logic [BEAT_W-1:0] beat;
  logic [BEAT_W-1:0] beat_next;
  logic [7:0]        cur_addr;
  logic [7:0]        cur_cmd;

  logic              out_free;
  logic              beat_load;
  out_kind_t         b_kind;
  logic [7:0]        b_tx;
  logic              b_last;
  status_t           b_status;
  logic [7:0]        b_code;
  logic [31:0]       b_data;

  function automatic logic [7:0] frame_byte(input logic [BEAT_W-1:0] idx,
                                            input logic [7:0] addr,
                                            input logic [7:0] cmd);
    logic [7:0] r;
    case (idx)
      3'd0:    r = HDR0;
      3'd1:    r = HDR1;
      3'd2:    r = addr;
      3'd3:    r = REQ_LEN;
      3'd4:    r = cmd;
      default: r = HDR0 ^ HDR1 ^ addr ^ REQ_LEN ^ cmd;
    endcase
    return r;
  endfunction

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_next = state;
    beat_next  = beat;
    if (out_free) begin
      case (state)
        BK_IDLE: begin
          if (!q_empty && q_head.kind == CMD_SEND) begin
            state_next = BK_SEND;
            beat_next  = BEAT_W'(1);
          end
        end
        BK_SEND: begin
          if (beat == LAST_BEAT) state_next = BK_IDLE;
          else beat_next = beat + 1'b1;
        end
        default: state_next = BK_IDLE;
      endcase
    end
  end

  always_comb begin
    pop       = 1'b0;
    beat_load = 1'b0;
    b_kind    = OUT_TX;
    b_tx      = 8'h00;
    b_last    = 1'b0;
    b_status  = ST_OK;
    b_code    = 8'h00;
    b_data    = 32'h0;
    case (state)
      BK_IDLE: begin
        if (out_free && !q_empty) begin
          pop       = 1'b1;
          beat_load = 1'b1;
          if (q_head.kind == CMD_SEND) begin
            b_tx = frame_byte('0, q_head.addr, q_head.cmd);
          end else begin
            b_kind   = OUT_DONE;
            b_status = q_head.status;
            b_code   = q_head.code;
            b_data   = q_head.data;
          end
        end
      end
      BK_SEND: begin
        beat_load = out_free;
        b_tx      = frame_byte(beat, cur_addr, cur_cmd);
        b_last    = (beat == LAST_BEAT);
      end
      default: beat_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_addr <= q_head.addr;
      cur_cmd  <= q_head.cmd;
    end
    if (beat_load) begin
      m_axis_tdata <= {(OUT_TDATA_W - OUT_FIELD_W)'(0), b_data, b_code, b_status, b_tx};
      m_axis_tuser <= b_kind;
      m_axis_tlast <= b_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_IDLE;
      beat          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      beat  <= beat_next;
      if (out_free) begin
        m_axis_tvalid <= beat_load;
      end
    end
  end

  `ASSERT_ALWAYS(a_last_only_on_tx, clk, rst, m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == OUT_TX)
  `ASSERT_ALWAYS(a_beat_in_frame, clk, rst, state == BK_SEND |-> beat != '0 && beat <= LAST_BEAT)

endmodule
`default_nettype wire
